// File: rtl/polyline_step_resampler_macros.svh
// ----------------------------------------------------------------------------
// polyline_step_resampler_macros.svh
// Assertion macros used by the resampler RTL.
// ----------------------------------------------------------------------------
`ifndef POLYLINE_STEP_RESAMPLER_MACROS_SVH
`define POLYLINE_STEP_RESAMPLER_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psr: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define PSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psr: next-cycle check failed");

`endif

// File: rtl/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Types, widths and codes of the polyline step resampler.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int COORD_W  = 24;
  localparam int LAYER_W  = 8;
  localparam int BASE_W   = 10;
  localparam int LEN_W    = 16;
  localparam int MUL_W    = 24;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int RAD_W    = 50;
  localparam int ROOT_W   = RAD_W / 2;
  localparam int DIV_N_W  = 42;
  localparam int DIV_D_W  = 26;
  localparam int DIV_Q_W  = 25;
  localparam int PCNT_W   = 11;

  localparam int MAX_VERTICES_DEF = 1024;
  localparam int MAX_POINTS_DEF   = 62;

  localparam logic [LEN_W-1:0] STEP_RESET    = 16'd256;
  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 16'd7680;

  // result kinds
  localparam logic [1:0] KIND_POINT  = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // stop reasons
  localparam logic [1:0] STOP_RUN    = 2'd0;
  localparam logic [1:0] STOP_LAYER  = 2'd1;
  localparam logic [1:0] STOP_BUDGET = 2'd2;
  localparam logic [1:0] STOP_VERTS  = 2'd3;

  // register word indexes
  localparam logic REG_STEP    = 1'b0;
  localparam logic REG_MAX_LEN = 1'b1;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [LAYER_W-1:0]        point_layer;
    logic [BASE_W-1:0]         base_index;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// File: rtl/psr_in_if.sv
// ----------------------------------------------------------------------------
// psr_in_if
// Vertex channel: valid/ready with the vertex fields.
// ----------------------------------------------------------------------------
interface psr_in_if;
  logic                               valid;
  logic                               ready;
  logic signed [psr_pkg::COORD_W-1:0] pos_x;
  logic signed [psr_pkg::COORD_W-1:0] pos_y;
  logic [psr_pkg::LAYER_W-1:0]        layer;
  logic                               last_vertex;

  modport source (output valid, pos_x, pos_y, layer, last_vertex, input ready);
  modport sink (input valid, pos_x, pos_y, layer, last_vertex, output ready);
endinterface

// File: rtl/psr_out_if.sv
// ----------------------------------------------------------------------------
// psr_out_if
// Result channel: valid/ready with the point and status fields.
// ----------------------------------------------------------------------------
interface psr_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         kind;
  logic signed [psr_pkg::COORD_W-1:0] point_x;
  logic signed [psr_pkg::COORD_W-1:0] point_y;
  logic [psr_pkg::LAYER_W-1:0]        point_layer;
  logic [psr_pkg::BASE_W-1:0]         base_index;
  logic                               last;

  modport source (output valid, kind, point_x, point_y, point_layer, base_index, last,
                  input ready);
  modport sink (input valid, kind, point_x, point_y, point_layer, base_index, last,
                output ready);
endinterface

// File: rtl/polyline_step_resampler.sv
// ----------------------------------------------------------------------------
// polyline_step_resampler
// Resamples a vertex stream at a fixed spacing along the polyline.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one path vertex per transfer; last_vertex closes a path.
//   out_ch carries sample points (kind 0) and, after the last vertex, one
//   status (1 accepted, 2 rejected); last marks the final result of a vertex.
//   step_length and max_length sit at APB byte addresses 0 and 4; write them
//   only while the block is idle.
// Operation:
//   in_ch.ready is high only between vertices. A walked segment computes
//   the squares and the 25-step square root, then for each emitted point
//   two interpolation divides of 25 steps on the shared divider, then one
//   divide and one multiply to skip dropped points. Results leave through a
//   one-entry holding stage and an output register, so the first result of
//   a vertex appears one result later than it is computed.
// Reset and stall:
//   rst (synchronous) restores both registers and starts a new path. When
//   out_ch stalls, the sequencer waits at its next result and holds.
// ----------------------------------------------------------------------------
`include "polyline_step_resampler_macros.svh"

module polyline_step_resampler #(
  parameter int MAX_VERTICES        = psr_pkg::MAX_VERTICES_DEF,
  parameter int MAX_POINTS_PER_ITEM = psr_pkg::MAX_POINTS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  psr_in_if.sink      in_ch,
  psr_out_if.source   out_ch
);

  localparam int VC_W  = $clog2(MAX_VERTICES + 1);
  localparam int E_W   = $clog2(MAX_POINTS_PER_ITEM + 1);
  localparam int CW    = psr_pkg::COORD_W;
  localparam int LW    = psr_pkg::LEN_W;

  typedef enum logic [4:0] {
    S_IDLE, S_SQ_X, S_SQ_Y, S_SQ_SUM, S_SQRT, S_LOOP,
    S_PX_MUL, S_PX_START, S_PX_WAIT, S_PY_MUL, S_PY_START, S_PY_WAIT,
    S_CNT_START, S_CNT_WAIT, S_CNT_MUL, S_CNT_ADD, S_UPD,
    S_FINISH, S_STATUS, S_PUSH, S_FLUSH
  } state_t;

  state_t state;
  state_t ret_state;

  // configuration
  logic [LW-1:0] step_length;
  logic [LW-1:0] max_length;

  // path state
  logic signed [CW-1:0]          prev_x;
  logic signed [CW-1:0]          prev_y;
  logic [psr_pkg::LAYER_W-1:0]   reference_layer;
  logic [VC_W-1:0]               vertex_count;
  logic [LW+1:0]                 passed_length;
  logic [LW:0]                   remaining_length;
  logic [1:0]                    stop_reason;
  logic [psr_pkg::PCNT_W-1:0]    point_count;

  // current vertex
  logic signed [CW-1:0]          cur_x;
  logic signed [CW-1:0]          cur_y;
  logic [psr_pkg::LAYER_W-1:0]   cur_layer;
  logic                          cur_last;
  logic [LW:0]                   step_r;
  logic [psr_pkg::BASE_W-1:0]    base_r;
  logic                          first_seg;
  logic                          upd_prev;
  logic                          neg_x;
  logic                          neg_y;
  logic [psr_pkg::MUL_W-1:0]     mag_x;
  logic [psr_pkg::MUL_W-1:0]     mag_y;
  logic [psr_pkg::PROD_W-1:0]    sq_acc;
  logic [psr_pkg::ROOT_W-1:0]    len_r;
  logic [LW-1:0]                 tgt;
  logic [LW+1:0]                 p;
  logic [E_W-1:0]                e_cnt;
  logic [psr_pkg::DIV_Q_W-1:0]   qx;

  // result staging
  psr_pkg::out_item_t push_item;
  psr_pkg::out_item_t staged;
  logic               staged_valid;
  psr_pkg::out_item_t out_item;
  logic               out_valid;
  logic               out_last;
  logic               out_free;
  logic               out_load;

  // shared units
  logic [psr_pkg::MUL_W-1:0]   mul_a;
  logic [psr_pkg::MUL_W-1:0]   mul_b;
  logic [psr_pkg::PROD_W-1:0]  mul_prod;
  logic                        sqrt_start;
  logic [psr_pkg::RAD_W-1:0]   radicand;
  logic [psr_pkg::ROOT_W-1:0]  root;
  psr_pkg::unit_status_t       sqrt_st;
  logic                        div_start;
  logic [psr_pkg::DIV_N_W-1:0] div_num;
  logic [psr_pkg::DIV_D_W-1:0] div_den;
  logic [psr_pkg::DIV_Q_W-1:0] div_quot;
  psr_pkg::unit_status_t       div_st;

  // accept-time helpers
  logic [CW:0]         dx_w;
  logic [CW:0]         dy_w;
  logic [CW:0]         adx_w;
  logic [CW:0]         ady_w;
  logic [VC_W-1:0]     vc_m1;
  logic [LW:0]         cnt1;
  logic                walk_more;
  logic                emit_more;
  logic signed [CW-1:0] px;
  logic signed [CW-1:0] py;

  psr_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (mul_prod)
  );

  psr_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sqrt_start),
    .radicand (radicand),
    .root     (root),
    .status   (sqrt_st)
  );

  psr_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quot   (div_quot),
    .status (div_st)
  );

  // APB access
  assign pready = 1'b1;
  always_comb begin
    case (paddr[2])
      psr_pkg::REG_STEP:    prdata = {16'd0, step_length};
      psr_pkg::REG_MAX_LEN: prdata = {16'd0, max_length};
      default:              prdata = '0;
    endcase
  end

  // segment deltas and magnitudes of the incoming vertex
  always_comb begin
    dx_w  = {in_ch.pos_x[CW-1], in_ch.pos_x} - {prev_x[CW-1], prev_x};
    dy_w  = {in_ch.pos_y[CW-1], in_ch.pos_y} - {prev_y[CW-1], prev_y};
    adx_w = dx_w[CW] ? (CW+1)'(-dx_w) : dx_w;
    ady_w = dy_w[CW] ? (CW+1)'(-dy_w) : dy_w;
    vc_m1 = vertex_count - 1'b1;
  end

  // loop decisions and interpolated point
  always_comb begin
    walk_more = (p <= {2'b00, tgt});
    emit_more = walk_more && (len_r != '0) && !first_seg
                && (e_cnt < E_W'(MAX_POINTS_PER_ITEM));
    cnt1      = {1'b0, div_quot[LW-1:0]} + (LW+1)'(1);
    px        = neg_x ? prev_x - qx[CW-1:0] : prev_x + qx[CW-1:0];
    py        = neg_y ? prev_y - div_quot[CW-1:0] : prev_y + div_quot[CW-1:0];
    out_free  = !out_valid || out_ch.ready;
    out_load  = staged_valid && out_free && (state == S_PUSH || state == S_FLUSH);
  end

  // operand selection for the shared units
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    sqrt_start = 1'b0;
    radicand   = {2'b00, sq_acc} + {2'b00, mul_prod};
    div_start  = 1'b0;
    div_num    = {mul_prod[psr_pkg::DIV_N_W-2:0], 1'b0}
                 + {{(psr_pkg::DIV_N_W - psr_pkg::ROOT_W){1'b0}}, len_r};
    div_den    = {len_r, 1'b0};
    case (state)
      S_SQ_X: begin
        mul_a = mag_x;
        mul_b = mag_x;
      end
      S_SQ_Y: begin
        mul_a = mag_y;
        mul_b = mag_y;
      end
      S_SQ_SUM: sqrt_start = 1'b1;
      S_PX_MUL: begin
        mul_a = mag_x;
        mul_b = {8'd0, p[LW-1:0]};
      end
      S_PY_MUL: begin
        mul_a = mag_y;
        mul_b = {8'd0, p[LW-1:0]};
      end
      S_PX_START, S_PY_START: div_start = 1'b1;
      S_CNT_START: begin
        div_start = 1'b1;
        div_num   = {{(psr_pkg::DIV_N_W - LW){1'b0}}, tgt - p[LW-1:0]};
        div_den   = {{(psr_pkg::DIV_D_W - LW - 1){1'b0}}, step_r};
      end
      S_CNT_MUL: begin
        mul_a = {7'd0, cnt1};
        mul_b = {7'd0, step_r};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      ret_state        <= S_IDLE;
      step_length      <= psr_pkg::STEP_RESET;
      max_length       <= psr_pkg::MAX_LEN_RESET;
      prev_x           <= '0;
      prev_y           <= '0;
      reference_layer  <= '0;
      vertex_count     <= '0;
      passed_length    <= '0;
      remaining_length <= '0;
      stop_reason      <= psr_pkg::STOP_RUN;
      point_count      <= '0;
      staged_valid     <= 1'b0;
      out_valid        <= 1'b0;
      e_cnt            <= '0;
    end else begin
      // configuration write
      if (psel && penable && pwrite) begin
        case (paddr[2])
          psr_pkg::REG_STEP:    step_length <= pwdata[LW-1:0];
          psr_pkg::REG_MAX_LEN: max_length  <= pwdata[LW-1:0];
          default: ;
        endcase
      end

      // drop the output once transferred, unless a new one loads
      if (out_valid && out_ch.ready && !out_load) out_valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            cur_x     <= in_ch.pos_x;
            cur_y     <= in_ch.pos_y;
            cur_layer <= in_ch.layer;
            cur_last  <= in_ch.last_vertex;
            step_r    <= (step_length == '0) ? (LW+1)'(1) : {1'b0, step_length};
            base_r    <= psr_pkg::BASE_W'(vc_m1);
            first_seg <= (vertex_count == VC_W'(1));
            neg_x     <= dx_w[CW];
            neg_y     <= dy_w[CW];
            mag_x     <= adx_w[CW-1:0];
            mag_y     <= ady_w[CW-1:0];
            p         <= passed_length;
            e_cnt     <= '0;
            if (vertex_count >= VC_W'(MAX_VERTICES)) begin
              upd_prev <= 1'b0;
              if (stop_reason == psr_pkg::STOP_RUN) stop_reason <= psr_pkg::STOP_VERTS;
              state    <= S_FINISH;
            end else begin
              upd_prev     <= 1'b1;
              vertex_count <= vertex_count + 1'b1;
              if (vertex_count == '0) begin
                passed_length    <= {2'b00, step_length};
                remaining_length <= {1'b0, max_length};
                state            <= S_FINISH;
              end else if (stop_reason != psr_pkg::STOP_RUN) begin
                state <= S_FINISH;
              end else if (vertex_count >= VC_W'(2) && in_ch.layer != reference_layer) begin
                stop_reason <= psr_pkg::STOP_LAYER;
                state       <= S_FINISH;
              end else begin
                if (vertex_count == VC_W'(1)) reference_layer <= in_ch.layer;
                state <= S_SQ_X;
              end
            end
          end
        end
        S_SQ_X: state <= S_SQ_Y;
        S_SQ_Y: begin
          sq_acc <= mul_prod;
          state  <= S_SQ_SUM;
        end
        S_SQ_SUM: state <= S_SQRT;
        S_SQRT: begin
          if (sqrt_st.done) begin
            len_r <= root;
            tgt   <= ({{(psr_pkg::ROOT_W - LW - 1){1'b0}}, remaining_length} < root)
                     ? remaining_length[LW-1:0] : root[LW-1:0];
            state <= S_LOOP;
          end
        end
        // emit points, then skip the rest of the walk on this segment
        S_LOOP: begin
          if (emit_more)      state <= S_PX_MUL;
          else if (walk_more) state <= S_CNT_START;
          else                state <= S_UPD;
        end
        S_PX_MUL:   state <= S_PX_START;
        S_PX_START: state <= S_PX_WAIT;
        S_PX_WAIT: begin
          if (div_st.done) begin
            qx    <= div_quot;
            state <= S_PY_MUL;
          end
        end
        S_PY_MUL:   state <= S_PY_START;
        S_PY_START: state <= S_PY_WAIT;
        S_PY_WAIT: begin
          if (div_st.done) begin
            push_item <= '{kind: psr_pkg::KIND_POINT, point_x: px, point_y: py,
                           point_layer: cur_layer, base_index: base_r};
            ret_state <= S_LOOP;
            p         <= p + {1'b0, step_r};
            e_cnt     <= e_cnt + 1'b1;
            if (point_count != '1) point_count <= point_count + 1'b1;
            state     <= S_PUSH;
          end
        end
        S_CNT_START: state <= S_CNT_WAIT;
        S_CNT_WAIT: if (div_st.done) state <= S_CNT_MUL;
        S_CNT_MUL:  state <= S_CNT_ADD;
        S_CNT_ADD: begin
          p     <= p + mul_prod[LW+1:0];
          state <= S_UPD;
        end
        // advance past the segment or stop on the budget
        S_UPD: begin
          if ({{(psr_pkg::ROOT_W - LW - 1){1'b0}}, remaining_length} > len_r) begin
            passed_length    <= p - (LW+2)'(len_r);
            remaining_length <= remaining_length - (LW+1)'(len_r);
          end else begin
            stop_reason <= psr_pkg::STOP_BUDGET;
          end
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (upd_prev) begin
            prev_x <= cur_x;
            prev_y <= cur_y;
          end
          if (!cur_last) begin
            state <= S_FLUSH;
          end else if (stop_reason == psr_pkg::STOP_RUN && vertex_count >= VC_W'(3)) begin
            push_item <= '{kind: psr_pkg::KIND_POINT, point_x: cur_x, point_y: cur_y,
                           point_layer: cur_layer,
                           base_index: psr_pkg::BASE_W'(vc_m1)};
            ret_state <= S_STATUS;
            if (point_count != '1) point_count <= point_count + 1'b1;
            state     <= S_PUSH;
          end else begin
            state <= S_STATUS;
          end
        end
        // close the path and start a new one
        S_STATUS: begin
          push_item <= '{kind: (vertex_count < VC_W'(3) || point_count < 11'd2)
                               ? psr_pkg::KIND_REJECT : psr_pkg::KIND_ACCEPT,
                         point_x: '0, point_y: '0, point_layer: '0, base_index: '0};
          ret_state        <= S_FLUSH;
          prev_x           <= '0;
          prev_y           <= '0;
          reference_layer  <= '0;
          vertex_count     <= '0;
          passed_length    <= '0;
          remaining_length <= '0;
          stop_reason      <= psr_pkg::STOP_RUN;
          point_count      <= '0;
          state            <= S_PUSH;
        end
        // hold one result back so the final one can carry last
        S_PUSH: begin
          if (!staged_valid) begin
            staged       <= push_item;
            staged_valid <= 1'b1;
            state        <= ret_state;
          end else if (out_free) begin
            out_item  <= staged;
            out_last  <= 1'b0;
            out_valid <= 1'b1;
            staged    <= push_item;
            state     <= ret_state;
          end
        end
        S_FLUSH: begin
          if (!staged_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_item     <= staged;
            out_last     <= 1'b1;
            out_valid    <= 1'b1;
            staged_valid <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // channel ports
  assign in_ch.ready        = (state == S_IDLE);
  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_item.kind;
  assign out_ch.point_x     = out_item.point_x;
  assign out_ch.point_y     = out_item.point_y;
  assign out_ch.point_layer = out_item.point_layer;
  assign out_ch.base_index  = out_item.base_index;
  assign out_ch.last        = out_last;

  // checks
  `PSR_ASSERT_NOW(a_idle_clean, in_ch.ready,
                  !staged_valid && !sqrt_st.busy && !div_st.busy)
  `PSR_ASSERT_NOW(a_emit_bound, 1'b1, e_cnt <= E_W'(MAX_POINTS_PER_ITEM))
  `PSR_ASSERT_NOW(a_status_last, out_valid && out_item.kind != psr_pkg::KIND_POINT,
                  out_last)
  `PSR_ASSERT_NEXT(a_accept_busy, in_ch.valid && in_ch.ready, !in_ch.ready)

endmodule

// File: rtl/psr_mul.sv
// ----------------------------------------------------------------------------
// psr_mul
// Shared unsigned 24x24 multiplier with a registered product.
// ----------------------------------------------------------------------------
module psr_mul (
  input  logic                        clk,
  input  logic [psr_pkg::MUL_W-1:0]   a,
  input  logic [psr_pkg::MUL_W-1:0]   b,
  output logic [psr_pkg::PROD_W-1:0]  prod
);

  // register the product every cycle
  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

// File: rtl/psr_isqrt.sv
// ----------------------------------------------------------------------------
// psr_isqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module psr_isqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [psr_pkg::RAD_W-1:0]    radicand,
  output logic [psr_pkg::ROOT_W-1:0]   root,
  output psr_pkg::unit_status_t        status
);

  localparam int REM_W = psr_pkg::ROOT_W + 2;
  localparam int CNT_W = $clog2(psr_pkg::ROOT_W + 1);

  logic [psr_pkg::RAD_W-1:0] rad;
  logic [REM_W-1:0]          rem;
  logic [CNT_W-1:0]          cnt;
  logic                      busy;
  logic                      done;
  logic [REM_W+1:0]          rem_sh;
  logic [REM_W+1:0]          trial;

  // bring down two bits, try root*4+1
  always_comb begin
    rem_sh = {rem, rad[psr_pkg::RAD_W-1 -: 2]};
    trial  = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= radicand;
        rem  <= '0;
        root <= '0;
        cnt  <= CNT_W'(psr_pkg::ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (rem_sh >= trial) begin
          rem  <= REM_W'(rem_sh - trial);
          root <= {root[psr_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= REM_W'(rem_sh);
          root <= {root[psr_pkg::ROOT_W-2:0], 1'b0};
        end
        rad <= {rad[psr_pkg::RAD_W-3:0], 2'b00};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule

// File: rtl/psr_div.sv
// ----------------------------------------------------------------------------
// psr_div
// Restoring divider, one quotient bit per cycle. The dividend must stay
// below den * 2**DIV_Q_W so that the quotient fits.
// ----------------------------------------------------------------------------
module psr_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [psr_pkg::DIV_N_W-1:0]   num,
  input  logic [psr_pkg::DIV_D_W-1:0]   den,
  output logic [psr_pkg::DIV_Q_W-1:0]   quot,
  output psr_pkg::unit_status_t         status
);

  localparam int Q_W   = psr_pkg::DIV_Q_W;
  localparam int D_W   = psr_pkg::DIV_D_W;
  localparam int N_W   = psr_pkg::DIV_N_W;
  localparam int CNT_W = $clog2(Q_W + 1);

  logic [D_W-1:0]   rem;
  logic [D_W-1:0]   den_r;
  logic [Q_W-1:0]   low;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic [D_W:0]     rem_sh;

  assign rem_sh = {rem, low[Q_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem   <= D_W'(num[N_W-1:Q_W]);
        low   <= num[Q_W-1:0];
        den_r <= den;
        quot  <= '0;
        cnt   <= CNT_W'(Q_W);
        busy  <= 1'b1;
      end else if (busy) begin
        // subtract when the shifted remainder covers the divisor
        if (rem_sh >= {1'b0, den_r}) begin
          rem  <= D_W'(rem_sh - {1'b0, den_r});
          quot <= {quot[Q_W-2:0], 1'b1};
        end else begin
          rem  <= D_W'(rem_sh);
          quot <= {quot[Q_W-2:0], 1'b0};
        end
        low <= {low[Q_W-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign status = '{busy: busy, done: done};

endmodule
